FILE: sv/angsep_pkg.sv
// ----------------------------------------------------------------------------
// Angular separation package
// Shared widths, fixed-point constants and helper functions for the
// great-circle separation pipeline.
// ----------------------------------------------------------------------------
package angsep_pkg;

    // Fixed-point format of the hour and degree ports.
    localparam int FRAC_BITS     = 16;
    // Number of micro-rotations in each CORDIC.
    localparam int CORDIC_STAGES = 20;
    // Number of isqrt iterations (one result bit each, 64-bit radicand).
    localparam int SQRT_STAGES   = 32;

    localparam int RA_W  = 21;
    localparam int DEC_W = 24;
    localparam int SEP_W = 24;

    // Four angles go through the sine/cosine pipeline side by side.
    localparam int NUM_ANG = 4;
    localparam int ANG_RA0  = 0;
    localparam int ANG_DEC0 = 1;
    localparam int ANG_RA1  = 2;
    localparam int ANG_DEC1 = 3;

    // Radian angle in Q30 before range reduction.
    typedef logic signed [35:0] t_ang;
    // CORDIC datapath word.
    typedef logic signed [33:0] t_cord;
    // Sine, cosine and vector components in Q30.
    typedef logic signed [31:0] t_q30;

    localparam t_ang  A_PI       = 36'sd3373259426;
    localparam t_ang  A_TWO_PI   = 36'sd6746518852;
    localparam t_ang  A_HALF_PI  = 36'sd1686629713;
    localparam t_cord C_HALF_PI  = 34'sd1686629713;
    localparam t_cord C_GAIN     = 34'sd652032875;
    localparam logic [28:0] Q_PI_12  = 29'd281104952;
    localparam logic signed [25:0] Q_PI_180 = 26'sd18740330;
    localparam logic [29:0] R2D_Q24  = 30'd961263669;
    localparam logic [63:0] Q_ONE_SQ = 64'd1 << 60;
    localparam t_q30  Q_ONE      = 32'sd1073741824;

    // Degree conversion and output saturation.
    localparam int DEG_SHIFT = 54 - FRAC_BITS;
    localparam longint SEP_FULL = longint'(180) << FRAC_BITS;
    localparam longint SEP_MAX  = (longint'(1) << SEP_W) - 1;
    localparam longint SEP_LIM  = (SEP_FULL > SEP_MAX) ? SEP_MAX : SEP_FULL;

    // Arctangent of 2^-idx in Q30 radians.
    function automatic t_cord atan_q30(input int unsigned idx);
        t_cord v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Right shift with rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] rshr_s64(input logic signed [63:0] v,
                                                    input int unsigned s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: sv/angular_separation.sv
// ----------------------------------------------------------------------------
// Angular separation
// Great-circle distance between two sky positions in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one position pair per transfer: right
//   ascension in hours and declination in degrees for each point, with
//   FRAC_BITS fraction bits. The output channel carries the separation in
//   degrees, 0 to 180, with the same fraction.
//   The block is a single pipeline with one shared advance enable. A new pair
//   can be taken in every cycle while o_stall is low; throughput is one
//   transfer per cycle when the receiver does not stall. The pipeline holds
//   the two CORDIC chains of one micro-rotation per stage and the 32-stage
//   square root.
//   Valid bits travel with the data through every stage. When the receiver
//   stalls while a result is held in the output register, the whole pipeline
//   holds and o_stall is raised; no data is lost or repeated. Empty stages
//   are not compressed during a stall.
//   Reset clears all valid bits; the pipeline is empty after reset and the
//   block is ready at once.
// ----------------------------------------------------------------------------
module angular_separation
    import angsep_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [RA_W-1:0]         i_first_ra,
    input  logic signed [DEC_W-1:0] i_first_dec,
    input  logic [RA_W-1:0]         i_second_ra,
    input  logic signed [DEC_W-1:0] i_second_dec,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SEP_W-1:0]        o_separation
);

    logic r_out_valid;
    logic en;

    // The pipeline advances unless a finished result is held by the receiver.
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: scale hours and degrees to radians.
    logic                r_s1_vld;
    logic [49:0]         r_s1_ra0;
    logic [49:0]         r_s1_ra1;
    logic signed [49:0]  r_s1_dec0;
    logic signed [49:0]  r_s1_dec1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ra0  <= 50'(i_first_ra) * 50'(Q_PI_12);
            r_s1_ra1  <= 50'(i_second_ra) * 50'(Q_PI_12);
            r_s1_dec0 <= 50'(i_first_dec) * 50'(Q_PI_180);
            r_s1_dec1 <= 50'(i_second_dec) * 50'(Q_PI_180);
        end
    end

    // Stage 2: round the products back to Q30.
    logic r_s2_vld;
    t_ang r_s2_ang [NUM_ANG];
    logic signed [63:0] dec0_rnd;
    logic signed [63:0] dec1_rnd;
    logic [49:0]        ra0_rnd;
    logic [49:0]        ra1_rnd;

    assign ra0_rnd  = (r_s1_ra0 + (50'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign ra1_rnd  = (r_s1_ra1 + (50'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign dec0_rnd = rshr_s64(64'(r_s1_dec0), FRAC_BITS);
    assign dec1_rnd = rshr_s64(64'(r_s1_dec1), FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ang[ANG_RA0]  <= $signed(ra0_rnd[35:0]);
            r_s2_ang[ANG_DEC0] <= dec0_rnd[35:0];
            r_s2_ang[ANG_RA1]  <= $signed(ra1_rnd[35:0]);
            r_s2_ang[ANG_DEC1] <= dec1_rnd[35:0];
        end
    end

    // Sine and cosine of all four angles.
    logic sc_vld;
    t_q30 sc_sin [NUM_ANG];
    t_q30 sc_cos [NUM_ANG];

    angsep_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_ang   (r_s2_ang),
        .o_valid (sc_vld),
        .o_sin   (sc_sin),
        .o_cos   (sc_cos)
    );

    // Unit vector products: cos dec times cos ra and sin ra.
    logic               r_m1_vld;
    logic signed [63:0] r_m1_x0;
    logic signed [63:0] r_m1_y0;
    logic signed [63:0] r_m1_x1;
    logic signed [63:0] r_m1_y1;
    t_q30               r_m1_z0;
    t_q30               r_m1_z1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= sc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_x0 <= 64'(sc_cos[ANG_DEC0]) * 64'(sc_cos[ANG_RA0]);
            r_m1_y0 <= 64'(sc_cos[ANG_DEC0]) * 64'(sc_sin[ANG_RA0]);
            r_m1_x1 <= 64'(sc_cos[ANG_DEC1]) * 64'(sc_cos[ANG_RA1]);
            r_m1_y1 <= 64'(sc_cos[ANG_DEC1]) * 64'(sc_sin[ANG_RA1]);
            r_m1_z0 <= sc_sin[ANG_DEC0];
            r_m1_z1 <= sc_sin[ANG_DEC1];
        end
    end

    // Round the vector components to Q30.
    logic r_r1_vld;
    t_q30 r_r1_x0;
    t_q30 r_r1_y0;
    t_q30 r_r1_x1;
    t_q30 r_r1_y1;
    t_q30 r_r1_z0;
    t_q30 r_r1_z1;
    logic signed [63:0] x0_rnd;
    logic signed [63:0] y0_rnd;
    logic signed [63:0] x1_rnd;
    logic signed [63:0] y1_rnd;

    assign x0_rnd = rshr_s64(r_m1_x0, 30);
    assign y0_rnd = rshr_s64(r_m1_y0, 30);
    assign x1_rnd = rshr_s64(r_m1_x1, 30);
    assign y1_rnd = rshr_s64(r_m1_y1, 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_vld <= 1'b0;
        end else if (en) begin
            r_r1_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1_x0 <= x0_rnd[31:0];
            r_r1_y0 <= y0_rnd[31:0];
            r_r1_x1 <= x1_rnd[31:0];
            r_r1_y1 <= y1_rnd[31:0];
            r_r1_z0 <= r_m1_z0;
            r_r1_z1 <= r_m1_z1;
        end
    end

    // Dot product terms.
    logic               r_m2_vld;
    logic signed [63:0] r_m2_xx;
    logic signed [63:0] r_m2_yy;
    logic signed [63:0] r_m2_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (en) begin
            r_m2_vld <= r_r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_xx <= 64'(r_r1_x0) * 64'(r_r1_x1);
            r_m2_yy <= 64'(r_r1_y0) * 64'(r_r1_y1);
            r_m2_zz <= 64'(r_r1_z0) * 64'(r_r1_z1);
        end
    end

    // Round each term.
    logic               r_r2_vld;
    t_q30               r_r2_xx;
    t_q30               r_r2_yy;
    t_q30               r_r2_zz;
    logic signed [63:0] xx_rnd;
    logic signed [63:0] yy_rnd;
    logic signed [63:0] zz_rnd;

    assign xx_rnd = rshr_s64(r_m2_xx, 30);
    assign yy_rnd = rshr_s64(r_m2_yy, 30);
    assign zz_rnd = rshr_s64(r_m2_zz, 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2_vld <= 1'b0;
        end else if (en) begin
            r_r2_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2_xx <= xx_rnd[31:0];
            r_r2_yy <= yy_rnd[31:0];
            r_r2_zz <= zz_rnd[31:0];
        end
    end

    // Sum and clamp to minus one through one.
    logic               r_dot_vld;
    t_q30               r_dot;
    logic signed [33:0] dot_sum;

    assign dot_sum = 34'(r_r2_xx) + 34'(r_r2_yy) + 34'(r_r2_zz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_vld <= 1'b0;
        end else if (en) begin
            r_dot_vld <= r_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (dot_sum > 34'(Q_ONE)) begin
                r_dot <= Q_ONE;
            end else if (dot_sum < -34'(Q_ONE)) begin
                r_dot <= -Q_ONE;
            end else begin
                r_dot <= dot_sum[31:0];
            end
        end
    end

    // Arc cosine.
    logic        ac_vld;
    logic [31:0] ac_ang;

    angsep_acos u_acos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_dot_vld),
        .i_cos   (r_dot),
        .o_valid (ac_vld),
        .o_ang   (ac_ang)
    );

    // Radians to degrees.
    logic        r_dm_vld;
    logic [63:0] r_dm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dm_vld <= 1'b0;
        end else if (en) begin
            r_dm_vld <= ac_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm <= 64'(ac_ang) * 64'(R2D_Q24);
        end
    end

    // Output register: round, then saturate at 180 degrees.
    logic [SEP_W-1:0] r_sep;
    logic [63:0]      deg;

    assign deg = (r_dm + (64'd1 << (DEG_SHIFT - 1))) >> DEG_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (deg > 64'(SEP_LIM)) begin
                r_sep <= SEP_W'(SEP_LIM);
            end else begin
                r_sep <= deg[SEP_W-1:0];
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_separation = r_sep;

endmodule

FILE: sv/angsep_sincos.sv
// ----------------------------------------------------------------------------
// Sine and cosine pipeline
// Reduces four Q30 radian angles to the right half plane and runs a
// rotation-mode CORDIC over them, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module angsep_sincos
    import angsep_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_ang i_ang [NUM_ANG],
    output logic o_valid,
    output t_q30 o_sin [NUM_ANG],
    output t_q30 o_cos [NUM_ANG]
);

    // Stage A: angle modulo two pi, keeping the sign.
    logic r_a_vld;
    t_ang r_a_ang [NUM_ANG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        t_ang m;
        if (i_en) begin
            for (int j = 0; j < NUM_ANG; j++) begin
                m = i_ang[j][35] ? -i_ang[j] : i_ang[j];
                if (m >= A_TWO_PI) begin
                    m = m - A_TWO_PI;
                end
                r_a_ang[j] <= i_ang[j][35] ? -m : m;
            end
        end
    end

    // Stage B: wrap into minus pi to pi, then fold into the right half plane.
    logic  r_vld [CORDIC_STAGES+1];
    t_cord r_x   [CORDIC_STAGES+1][NUM_ANG];
    t_cord r_y   [CORDIC_STAGES+1][NUM_ANG];
    t_cord r_z   [CORDIC_STAGES+1][NUM_ANG];
    logic  r_neg [CORDIC_STAGES+1][NUM_ANG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        t_ang r;
        logic ng;
        if (i_en) begin
            for (int j = 0; j < NUM_ANG; j++) begin
                r  = r_a_ang[j];
                ng = 1'b0;
                if (r > A_PI) begin
                    r = r - A_TWO_PI;
                end
                if (r < -A_PI) begin
                    r = r + A_TWO_PI;
                end
                if (r > A_HALF_PI) begin
                    r  = r - A_PI;
                    ng = 1'b1;
                end else if (r < -A_HALF_PI) begin
                    r  = r + A_PI;
                    ng = 1'b1;
                end
                r_x[0][j]   <= C_GAIN;
                r_y[0][j]   <= '0;
                r_z[0][j]   <= r[33:0];
                r_neg[0][j] <= ng;
            end
        end
    end

    // CORDIC micro-rotations, one per stage.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < NUM_ANG; j++) begin
                    if (!r_z[k][j][33]) begin
                        r_x[k+1][j] <= r_x[k][j] - (r_y[k][j] >>> k);
                        r_y[k+1][j] <= r_y[k][j] + (r_x[k][j] >>> k);
                        r_z[k+1][j] <= r_z[k][j] - atan_q30(k);
                    end else begin
                        r_x[k+1][j] <= r_x[k][j] + (r_y[k][j] >>> k);
                        r_y[k+1][j] <= r_y[k][j] - (r_x[k][j] >>> k);
                        r_z[k+1][j] <= r_z[k][j] + atan_q30(k);
                    end
                    r_neg[k+1][j] <= r_neg[k][j];
                end
            end
        end
    end

    // Output stage: undo the half-plane fold.
    logic r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        t_cord c;
        t_cord s;
        if (i_en) begin
            for (int j = 0; j < NUM_ANG; j++) begin
                c = r_neg[CORDIC_STAGES][j] ? -r_x[CORDIC_STAGES][j] : r_x[CORDIC_STAGES][j];
                s = r_neg[CORDIC_STAGES][j] ? -r_y[CORDIC_STAGES][j] : r_y[CORDIC_STAGES][j];
                o_cos[j] <= c[31:0];
                o_sin[j] <= s[31:0];
            end
        end
    end

    assign o_valid = r_o_vld;

endmodule

FILE: sv/angsep_acos.sv
// ----------------------------------------------------------------------------
// Arc cosine pipeline
// Forms sqrt(1 - c*c) with a pipelined integer square root and runs a
// vectoring-mode CORDIC on (c, sqrt) to get the angle in Q30 radians.
// ----------------------------------------------------------------------------
module angsep_acos
    import angsep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_q30        i_cos,
    output logic        o_valid,
    output logic [31:0] o_ang
);

    // Square of the cosine.
    logic        r_cc_vld;
    logic [63:0] r_cc;
    t_q30        r_cc_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_vld <= 1'b0;
        end else if (i_en) begin
            r_cc_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc   <= 64'(64'(i_cos) * 64'(i_cos));
            r_cc_c <= i_cos;
        end
    end

    // Radicand, then one result bit per stage.
    logic        r_sq_vld [SQRT_STAGES+1];
    logic [63:0] r_sq_v   [SQRT_STAGES+1];
    logic [63:0] r_sq_r   [SQRT_STAGES+1];
    t_q30        r_sq_c   [SQRT_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_vld[0] <= r_cc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_v[0] <= Q_ONE_SQ - r_cc;
            r_sq_r[0] <= '0;
            r_sq_c[0] <= r_cc_c;
        end
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [63:0] trial;
            if (i_en) begin
                trial = r_sq_r[k] + SQ_BIT;
                if (r_sq_v[k] >= trial) begin
                    r_sq_v[k+1] <= r_sq_v[k] - trial;
                    r_sq_r[k+1] <= (r_sq_r[k] >> 1) + SQ_BIT;
                end else begin
                    r_sq_v[k+1] <= r_sq_v[k];
                    r_sq_r[k+1] <= r_sq_r[k] >> 1;
                end
                r_sq_c[k+1] <= r_sq_c[k];
            end
        end
    end

    // Vector setup; a negative cosine is turned by minus a quarter turn first.
    logic  r_vld [CORDIC_STAGES+1];
    t_cord r_x   [CORDIC_STAGES+1];
    t_cord r_y   [CORDIC_STAGES+1];
    t_cord r_z   [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_sq_vld[SQRT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        t_cord c;
        t_cord s;
        if (i_en) begin
            c = 34'(r_sq_c[SQRT_STAGES]);
            s = $signed(r_sq_r[SQRT_STAGES][33:0]);
            if (c[33]) begin
                r_x[0] <= s;
                r_y[0] <= -c;
                r_z[0] <= C_HALF_PI;
            end else begin
                r_x[0] <= c;
                r_y[0] <= s;
                r_z[0] <= '0;
            end
        end
    end

    // Vectoring micro-rotations drive y toward zero.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[k][33] && (r_y[k] != '0)) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q30(k);
                end
            end
        end
    end

    // Output stage: a slightly negative angle reads as zero.
    logic        r_o_vld;
    logic [31:0] r_o_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_ang <= r_z[CORDIC_STAGES][33] ? 32'd0 : r_z[CORDIC_STAGES][31:0];
        end
    end

    assign o_valid = r_o_vld;
    assign o_ang   = r_o_ang;

endmodule

FILE: sim/angular_separation_chk.sv
// ----------------------------------------------------------------------------
// Angular separation checker
// Watches both channels of the separation pipeline, computes the expected
// great-circle distance of every accepted position pair and compares it with
// every result transfer in order.
// ----------------------------------------------------------------------------
module angular_separation_chk
    import angsep_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_stall_in,
    input  logic [RA_W-1:0]         i_first_ra,
    input  logic signed [DEC_W-1:0] i_first_dec,
    input  logic [RA_W-1:0]         i_second_ra,
    input  logic signed [DEC_W-1:0] i_second_dec,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [SEP_W-1:0]        i_separation,
    output int                      o_errors,
    output int                      o_pending
);

    typedef longint signed s64;

    logic [SEP_W-1:0] sep_queue[$];
    int               err_cnt;

    // Arctangent of 2^-k in Q30 radians.
    function automatic s64 arctan_step(input int k);
        s64 tab[32];
        tab = '{843314857, 497837829, 263043836, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                128, 64, 32, 16, 8, 4, 2, 1, 0};
        return tab[k];
    endfunction

    // Shift right rounding to nearest, ties away from zero.
    function automatic s64 round_shift(input s64 v, input int s);
        s64 m;
        m = (v < 0) ? -v : v;
        m = (m + (s64'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic s64 q30_mul(input s64 a, input s64 b);
        return round_shift(a * b, 30);
    endfunction

    // Rotation CORDIC after reduction to the right half plane.
    function automatic void sin_cos(input s64 a, output s64 sn, output s64 cs);
        s64 r, x, y, z, t;
        bit neg;
        r = ((a < 0) ? -a : a) % 64'sd6746518852;
        if (a < 0) r = -r;
        if (r > 64'sd3373259426) r -= 64'sd6746518852;
        if (r < -64'sd3373259426) r += 64'sd6746518852;
        neg = 0;
        if (r > 64'sd1686629713) begin
            r -= 64'sd3373259426;
            neg = 1;
        end else if (r < -64'sd1686629713) begin
            r += 64'sd3373259426;
            neg = 1;
        end
        x = 652032875;
        y = 0;
        z = r;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end
            x = t;
        end
        cs = neg ? -x : x;
        sn = neg ? -y : y;
    endfunction

    function automatic s64 int_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return s64'(res);
    endfunction

    // Vectoring CORDIC arc cosine, Q30 in and out.
    function automatic s64 arc_cos(input s64 c);
        s64 s, x, y, z, t;
        s = int_sqrt(64'(s64'(1) << 60) - 64'(c * c));
        x = c;
        y = s;
        z = 0;
        if (x < 0) begin
            x = s;
            y = -c;
            z = 1686629713;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (y > 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end
            x = t;
        end
        return z;
    endfunction

    function automatic void to_vector(input logic [RA_W-1:0] ra,
                                      input logic signed [DEC_W-1:0] dec,
                                      output s64 vx, output s64 vy, output s64 vz);
        s64 sp, cp, sd, cd;
        sin_cos(round_shift(s64'(ra) * 281104952, FRAC_BITS), sp, cp);
        sin_cos(round_shift(s64'(dec) * 18740330, FRAC_BITS), sd, cd);
        vx = q30_mul(cd, cp);
        vy = q30_mul(cd, sp);
        vz = sd;
    endfunction

    function automatic logic [SEP_W-1:0] separation_of(
            input logic [RA_W-1:0] ra0, input logic signed [DEC_W-1:0] dec0,
            input logic [RA_W-1:0] ra1, input logic signed [DEC_W-1:0] dec1);
        s64 x0, y0, z0, x1, y1, z1, dot, ang, deg, lim;
        to_vector(ra0, dec0, x0, y0, z0);
        to_vector(ra1, dec1, x1, y1, z1);
        dot = q30_mul(x0, x1) + q30_mul(y0, y1) + q30_mul(z0, z1);
        if (dot > 64'sd1073741824) dot = 64'sd1073741824;
        if (dot < -64'sd1073741824) dot = -64'sd1073741824;
        ang = arc_cos(dot);
        if (ang < 0) ang = 0;
        deg = round_shift(ang * 961263669, 54 - FRAC_BITS);
        lim = s64'(180) << FRAC_BITS;
        if (lim > 24'hFFFFFF) lim = 24'hFFFFFF;
        if (deg > lim) deg = lim;
        if (deg < 0) deg = 0;
        return deg[SEP_W-1:0];
    endfunction

    // Predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin
        logic [SEP_W-1:0] want;
        if (!i_rst_n) begin
            sep_queue.delete();
            err_cnt <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                sep_queue.push_back(separation_of(i_first_ra, i_first_dec,
                                                  i_second_ra, i_second_dec));
            if (i_out_valid && !i_out_stall) begin
                if (sep_queue.size() == 0) begin
                    $error("separation: unexpected result %0d", i_separation);
                    err_cnt <= err_cnt + 1;
                end else begin
                    want = sep_queue.pop_front();
                    if (want !== i_separation) begin
                        $error("separation: expected %0d, actual %0d", want,
                               i_separation);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
        end
    end

    assign o_errors  = err_cnt;
    assign o_pending = sep_queue.size();

endmodule

FILE: sim/angular_separation_tb.sv
// ----------------------------------------------------------------------------
// Angular separation testbench
// Drives directed and random position pairs with bursty input and a stalling
// receiver, including a long output hold-off and a full drain, and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module angular_separation_tb;
    import angsep_pkg::*;

    localparam int LATENCY   = 2 * CORDIC_STAGES + 48;
    localparam int RAND_ITEMS = 1450;
    localparam int MAX_CYCLES = 400000;

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    in_valid = 0;
    logic                    in_stall;
    logic [RA_W-1:0]         first_ra = 0;
    logic signed [DEC_W-1:0] first_dec = 0;
    logic [RA_W-1:0]         second_ra = 0;
    logic signed [DEC_W-1:0] second_dec = 0;
    logic                    out_valid;
    logic                    out_stall = 1;
    logic [SEP_W-1:0]        separation;
    int                      errors, pending;
    int                      cycle_cnt = 0;
    bit                      hold_off = 0;

    always #1 i_clk = ~i_clk;

    angular_separation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_first_ra(first_ra), .i_first_dec(first_dec), .i_second_ra(second_ra),
        .i_second_dec(second_dec), .o_valid(out_valid), .i_stall(out_stall),
        .o_separation(separation)
    );

    angular_separation_chk checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_first_ra(first_ra), .i_first_dec(first_dec), .i_second_ra(second_ra),
        .i_second_dec(second_dec), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_separation(separation), .o_errors(errors), .o_pending(pending)
    );

    // Random declination: mostly within +-90 deg, sometimes any 24-bit value.
    function automatic logic signed [DEC_W-1:0] pick_dec();
        if ($urandom_range(9) == 0) return DEC_W'($urandom);
        return DEC_W'($signed($urandom_range(11796480)) - 5898240);
    endfunction

    function automatic logic [RA_W-1:0] pick_ra();
        if ($urandom_range(9) == 0) return RA_W'($urandom);
        return RA_W'($urandom_range(1572863));
    endfunction

    // Offer one pair and hold it until the transfer happens.
    task automatic send_pair(input logic [RA_W-1:0] ra0,
                             input logic signed [DEC_W-1:0] dec0,
                             input logic [RA_W-1:0] ra1,
                             input logic signed [DEC_W-1:0] dec1);
        first_ra   <= ra0;
        first_dec  <= dec0;
        second_ra  <= ra1;
        second_dec <= dec1;
        in_valid   <= 1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            in_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Receiver stall pattern, with phases of no stalling and one long hold-off.
    always @(posedge i_clk) begin
        int mode;
        if (!i_rst_n) begin
            out_stall <= 1;
            mode = 0;
        end else begin
            if ($urandom_range(199) == 0) mode = $urandom_range(2);
            if (hold_off) out_stall <= 1;
            else case (mode)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(3) == 0);
                default: out_stall <= ($urandom_range(3) != 0);
            endcase
        end
    end

    // Long hold-off counted here, while the sender keeps offering pairs.
    initial begin
        @(posedge i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (3 * LATENCY) @(posedge i_clk);
        hold_off = 0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [RA_W-1:0]         ra_ext[4];
        logic signed [DEC_W-1:0] dec_ext[6];
        logic [RA_W-1:0]         near_ra;
        logic signed [DEC_W-1:0] near_dec;
        bit                      drained;
        int                      burst;
        ra_ext  = '{0, 786432, 1572863, 2097151};
        dec_ext = '{0, 5898240, -5898240, 8388607, -8388608, 1};
        drained = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: same point, poles, opposite points, field extremes.
        send_pair(0, 0, 0, 0);
        send_pair(0, 5898240, 0, -5898240);
        send_pair(0, 0, 786432, 0);
        send_pair(1572863, 0, 0, 0);
        send_pair(2097151, 8388607, 0, -8388608);
        send_pair(393216, 2949120, 393216, 2949121);
        send_pair(1, 1, 0, 0);
        for (int k = 0; k < 16; k++)
            send_pair(ra_ext[k % 4], dec_ext[k % 6], ra_ext[(k / 4) % 4],
                      dec_ext[(k + 3) % 6]);

        // Random bursts with gaps.
        for (int n = 0; n < RAND_ITEMS; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RAND_ITEMS; b++, n++) begin
                if ($urandom_range(7) == 0)
                    send_pair(pick_ra(), pick_dec(), pick_ra(), pick_dec());
                else begin
                    near_ra  = pick_ra();
                    near_dec = pick_dec();
                    // Nearby pairs exercise small separations.
                    send_pair(near_ra, near_dec,
                              RA_W'(near_ra + $urandom_range(255)),
                              DEC_W'(near_dec - $signed($urandom_range(255))));
                end
            end
            if (!drained && n >= RAND_ITEMS / 2) begin
                drained = 1;
                in_valid <= 0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end else begin
                idle_cycles($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30));
            end
        end
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
